[design/rgb_led_pwm_bit_encoder_macros.svh]
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder assertion macros
// Shared assertion helpers; every use relies on clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PWM_BIT_ENCODER_MACROS_SVH
`define RGB_LED_PWM_BIT_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge outside reset.
`define RLPBE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rlpbe assertion failed");

// Checked at every rising edge, reset included.
`define RLPBE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rlpbe assertion failed");

`else

`define RLPBE_ASSERT(label, prop)
`define RLPBE_ASSERT_ALWAYS(label, prop)

`endif

`endif

[design/rlpbe_pkg.sv]
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder package
// Widths, codes, reset values, the brightness ROM and shared types.
// ----------------------------------------------------------------------------
package rlpbe_pkg;

  // Field widths.
  localparam int CHAN_W     = 8;
  localparam int DUTY_W     = 16;
  localparam int BRIGHT_W   = 6;
  localparam int TRAIL_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COEF_W     = 17;
  localparam int PROD_W     = CHAN_W + COEF_W;

  // Pixel word and run lengths.
  localparam int PIX_BITS    = 3 * CHAN_W;
  localparam int PIX_LAST    = PIX_BITS - 1;
  localparam int BIT_IDX_W   = $clog2(PIX_BITS);
  localparam int MAX_TRAILER = 64;
  localparam int SLOT_W      = $clog2(MAX_TRAILER);

  // Brightness ROM and defaults for the top-level parameters.
  localparam int ROM_DEPTH           = 46;
  localparam int ROM_TOP             = ROM_DEPTH - 1;
  localparam int BRIGHT_STEPS_DEFAULT = 46;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Item kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_DUTY       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DUTY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_LENGTH = 2'd3;

  // Register reset values.
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST  = 6'd45;
  localparam logic [DUTY_W-1:0]   ONE_RST     = 16'd150;
  localparam logic [DUTY_W-1:0]   ZERO_RST    = 16'd75;
  localparam logic [TRAIL_W-1:0]  TRAILER_RST = 7'd50;

  // round(tan(k degrees) * 65536) for k = 0 to 45.
  localparam logic [COEF_W-1:0] TAN_ROM [0:ROM_DEPTH-1] = '{
    17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
    17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
    17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
    17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
    17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
    17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
    17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
    17'd59009, 17'd61113, 17'd63287, 17'd65536
  };

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic [DUTY_W-1:0]   one_duty;
    logic [DUTY_W-1:0]   zero_duty;
    logic [TRAIL_W-1:0]  trailer_length;
  } cfg_t;

  // One queued work item: its kind and the packed GRB word.
  typedef struct packed {
    logic                kind;
    logic [PIX_BITS-1:0] word;
  } q_entry_t;

endpackage

[design/rlpbe_front.sv]
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder front end
// Accepts items, scales the pixel channels and packs them into a GRB word.
// ----------------------------------------------------------------------------
module rlpbe_front (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [rlpbe_pkg::CHAN_W-1:0]   in_red,
  input  logic [rlpbe_pkg::CHAN_W-1:0]   in_green,
  input  logic [rlpbe_pkg::CHAN_W-1:0]   in_blue,
  input  rlpbe_pkg::cfg_t                cfg,
  input  logic                           q_full,
  output logic                           q_push,
  output rlpbe_pkg::q_entry_t            q_data
);

  logic [rlpbe_pkg::COEF_W-1:0] coef;
  logic [rlpbe_pkg::PROD_W-1:0] prod_r;
  logic [rlpbe_pkg::PROD_W-1:0] prod_g;
  logic [rlpbe_pkg::PROD_W-1:0] prod_b;

  // A transfer is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  // Brightness coefficient; the register is already saturated to the ROM range.
  assign coef = rlpbe_pkg::TAN_ROM[cfg.brightness];

  // Each channel times the coefficient, keeping the integer part.
  assign prod_r = rlpbe_pkg::PROD_W'(in_red)   * rlpbe_pkg::PROD_W'(coef);
  assign prod_g = rlpbe_pkg::PROD_W'(in_green) * rlpbe_pkg::PROD_W'(coef);
  assign prod_b = rlpbe_pkg::PROD_W'(in_blue)  * rlpbe_pkg::PROD_W'(coef);

  // Pack as green, red, blue; an end of frame carries no word.
  always_comb begin
    q_data.kind = in_kind;
    if (in_kind == rlpbe_pkg::KIND_EOF) begin
      q_data.word = '0;
    end else begin
      q_data.word = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
    end
  end

endmodule

[design/rlpbe_fifo.sv]
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder item queue
// Short first-in first-out queue between the front end and the serialiser.
// ----------------------------------------------------------------------------
`include "rgb_led_pwm_bit_encoder_macros.svh"

module rlpbe_fifo #(
  parameter int DEPTH = rlpbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rlpbe_pkg::q_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output rlpbe_pkg::q_entry_t head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rlpbe_pkg::q_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r,  count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entries_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // The fill count never passes the depth, and an empty queue has met pointers.
  `RLPBE_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH))
  `RLPBE_ASSERT(a_empty_ptrs, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))

endmodule

[design/rlpbe_serial.sv]
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder serialiser
// Turns the queue head into one duty slot per unstalled cycle behind an output register.
// ----------------------------------------------------------------------------
`include "rgb_led_pwm_bit_encoder_macros.svh"

module rlpbe_serial (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlpbe_pkg::cfg_t              cfg,
  input  logic                         head_valid,
  input  rlpbe_pkg::q_entry_t          head_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rlpbe_pkg::DUTY_W-1:0] out_duty,
  output logic                         out_last
);

  logic [rlpbe_pkg::SLOT_W-1:0]    cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rlpbe_pkg::DUTY_W-1:0]    duty_r;
  logic                            last_r;
  logic [rlpbe_pkg::SLOT_W-1:0]    trail_last;
  logic [rlpbe_pkg::SLOT_W-1:0]    run_last;
  logic [rlpbe_pkg::BIT_IDX_W-1:0] bit_idx;
  logic                            slot_last;
  logic [rlpbe_pkg::DUTY_W-1:0]    slot_duty;
  logic                            load;

  // Trailer run length, with zero read as one and long runs cut to the maximum.
  always_comb begin
    if (cfg.trailer_length == '0) begin
      trail_last = '0;
    end else if (cfg.trailer_length > rlpbe_pkg::TRAIL_W'(rlpbe_pkg::MAX_TRAILER)) begin
      trail_last = rlpbe_pkg::SLOT_W'(rlpbe_pkg::MAX_TRAILER - 1);
    end else begin
      trail_last = rlpbe_pkg::SLOT_W'(cfg.trailer_length - 1'b1);
    end
  end

  // Current slot: most significant bit first for a pixel, zero duty for a trailer.
  always_comb begin
    bit_idx = rlpbe_pkg::BIT_IDX_W'(rlpbe_pkg::PIX_LAST)
              - cnt_r[rlpbe_pkg::BIT_IDX_W-1:0];
    if (head_data.kind == rlpbe_pkg::KIND_EOF) begin
      run_last  = trail_last;
      slot_duty = '0;
    end else begin
      run_last  = rlpbe_pkg::SLOT_W'(rlpbe_pkg::PIX_LAST);
      slot_duty = head_data.word[bit_idx] ? cfg.one_duty : cfg.zero_duty;
    end
    slot_last = (cnt_r == run_last);
  end

  // A slot moves into the output register when it is empty or being taken.
  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && slot_last;

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = slot_last ? '0 : cnt_r + 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      duty_r <= slot_duty;
      last_r <= slot_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = duty_r;
  assign out_last  = last_r;

  // Reset empties the output; the slot count rests at zero between items and
  // never runs past the end of the current run.
  `RLPBE_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && cnt_r == '0))
  `RLPBE_ASSERT(a_idle_count, !head_valid |-> (cnt_r == '0))
  `RLPBE_ASSERT(a_run_bound, head_valid |-> (cnt_r <= run_last))

endmodule

[design/rgb_led_pwm_bit_encoder.sv]
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder
// Each pixel item yields 24 duty slots, one per clock while out_stall is low,
// in GRB order with the most significant bit first, every channel first
// scaled by tan(brightness degrees); an end-of-frame item yields
// trailer_length zero slots (1 to 64). The serialiser's output register
// emits one slot per cycle while out_stall is low. Items are taken while
// the item queue has room; when the queue is empty, the first slot of an
// item is written to a queue entry and then registered in the serialiser's
// output register before it is offered. Configuration is written through
// the plain write port and takes effect once registered.
// ----------------------------------------------------------------------------
module rgb_led_pwm_bit_encoder #(
  parameter int BRIGHT_STEPS = rlpbe_pkg::BRIGHT_STEPS_DEFAULT,
  parameter int QUEUE_DEPTH  = rlpbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rlpbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlpbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [rlpbe_pkg::CHAN_W-1:0]     in_red,
  input  logic [rlpbe_pkg::CHAN_W-1:0]     in_green,
  input  logic [rlpbe_pkg::CHAN_W-1:0]     in_blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rlpbe_pkg::DUTY_W-1:0]     out_duty,
  output logic                             out_last
);

  // Highest usable brightness index.
  localparam int BRIGHT_TOP = (BRIGHT_STEPS - 1 < rlpbe_pkg::ROM_TOP) ?
                              BRIGHT_STEPS - 1 : rlpbe_pkg::ROM_TOP;

  rlpbe_pkg::cfg_t                cfg_r, cfg_nxt;
  logic [rlpbe_pkg::BRIGHT_W-1:0] bright_wr;
  logic                           q_push;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_head_valid;
  rlpbe_pkg::q_entry_t            q_push_data;
  rlpbe_pkg::q_entry_t            q_head_data;

  // Configuration writes; brightness saturates at the top ROM index.
  always_comb begin
    bright_wr = cfg_wdata[rlpbe_pkg::BRIGHT_W-1:0];
    cfg_nxt   = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rlpbe_pkg::CFG_BRIGHTNESS: begin
          cfg_nxt.brightness = (bright_wr > rlpbe_pkg::BRIGHT_W'(BRIGHT_TOP)) ?
                               rlpbe_pkg::BRIGHT_W'(BRIGHT_TOP) : bright_wr;
        end
        rlpbe_pkg::CFG_ONE_DUTY: begin
          cfg_nxt.one_duty = cfg_wdata[rlpbe_pkg::DUTY_W-1:0];
        end
        rlpbe_pkg::CFG_ZERO_DUTY: begin
          cfg_nxt.zero_duty = cfg_wdata[rlpbe_pkg::DUTY_W-1:0];
        end
        rlpbe_pkg::CFG_TRAILER_LENGTH: begin
          cfg_nxt.trailer_length = cfg_wdata[rlpbe_pkg::TRAIL_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness     <= (rlpbe_pkg::BRIGHT_RST > rlpbe_pkg::BRIGHT_W'(BRIGHT_TOP)) ?
                              rlpbe_pkg::BRIGHT_W'(BRIGHT_TOP) : rlpbe_pkg::BRIGHT_RST;
      cfg_r.one_duty       <= rlpbe_pkg::ONE_RST;
      cfg_r.zero_duty      <= rlpbe_pkg::ZERO_RST;
      cfg_r.trailer_length <= rlpbe_pkg::TRAILER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accepts and scales items.
  rlpbe_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // Item queue between the two halves.
  rlpbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  // Back end: one duty slot per cycle while out_stall is low.
  rlpbe_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_duty   (out_duty),
    .out_last   (out_last)
  );

endmodule
